[sv/hcps_pkg.sv]
// Package for the hash-consed pair store: sizes, codes, FNV constants and
// the control structs passed between the core and the hash unit.
// No dependencies.
package hcps_pkg;

  // Store sizes (HASH_DEPTH is a power of two; the hash index is masked)
  localparam int NODE_DEPTH = 1024;
  localparam int HASH_DEPTH = 2048;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int HASH_AW    = $clog2(HASH_DEPTH);
  localparam int CNT_W      = 11;
  localparam int LOAD_LIMIT = HASH_DEPTH - HASH_DEPTH / 4;

  // 64-bit FNV-1a
  localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME  = 64'h00000100000001B3;

  localparam logic [31:0] BASE_RESET = 32'h80000000;

  typedef enum logic [1:0] {
    CMD_CONS  = 2'd0,
    CMD_CAR   = 2'd1,
    CMD_CDR   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NEW    = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PRD,
    S_PCHK,
    S_NRD,
    S_NSEL,
    S_RESP
  } state_t;

  // Hash unit request / response
  typedef struct packed {
    logic        start;
    logic [31:0] head;
    logic [31:0] tail;
  } fnv_req_t;

  typedef struct packed {
    logic               done;
    logic [HASH_AW-1:0] idx;
  } fnv_rsp_t;

endpackage

[sv/hcps_if.sv]
// Channel interfaces for the hash-consed pair store: input, result and
// configuration write channels. Depends on nothing.
interface hcps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] head_value;
  logic [31:0] tail_value;
  logic [31:0] handle;
  modport source (output valid, cmd, head_value, tail_value, handle, input ready);
  modport sink (input valid, cmd, head_value, tail_value, handle, output ready);
endinterface

interface hcps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  status;
  logic        dirty;
  logic [10:0] nodes_used;
  modport source (output valid, value, status, dirty, nodes_used, input ready);
  modport sink (input valid, value, status, dirty, nodes_used, output ready);
endinterface

interface hcps_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/hcps_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module hcps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/hcps_fnv.sv]
// Iterative FNV-1a hash unit, one byte of the (head, tail) pair per cycle.
// Only the low index bits are kept; they depend only on the low operand bits.
// Depends on hcps_pkg.
module hcps_fnv
  import hcps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  fnv_req_t req,
  output fnv_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [HASH_AW-1:0] h_r, h_nxt;
  logic [63:0]        word_r, word_nxt;
  logic [7:0]         cur_byte;
  logic [HASH_AW-1:0] mixed;

  // current byte, little-endian, head first
  assign cur_byte = word_r[8*k_r +: 8];
  assign mixed    = h_r ^ HASH_AW'(cur_byte);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    h_nxt    = h_r;
    word_nxt = word_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      k_nxt    = 3'd0;
      h_nxt    = FNV_OFFSET[HASH_AW-1:0];
      word_nxt = {req.tail, req.head};
    end else if (busy_r) begin
      h_nxt = HASH_AW'(mixed * FNV_PRIME[HASH_AW-1:0]);
      k_nxt = k_r + 3'd1;
      if (k_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r    <= k_nxt;
    h_r    <= h_nxt;
    word_r <= word_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.idx  = h_r;

endmodule

[sv/hash_consed_pair_store_core.sv]
// Top level of the hash-consed pair store: command sequencer, node and slot
// memories, FNV hash unit and result register.
// Depends on hcps_pkg, hcps_if, hcps_ram and hcps_fnv.

// Usage: after reset the block sweeps the slot table clear, writing all
// HASH_DEPTH (2048) slots with in_ch.ready low; configuration writes are
// taken throughout. One item is handled at a time. Clear-dirty, rejected
// items and empty-list reads go straight to the result state; car/cdr do
// one node memory read. A cons runs the byte-serial FNV hash, then probes
// the slot memory with a read and a check per slot visited, then posts the
// result. The next item is taken as soon as the result is in the output
// register.
module hash_consed_pair_store_core
  import hcps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  hcps_in_if.sink    in_ch,
  hcps_out_if.source out_ch,
  hcps_cfg_if.sink   cfg_ch
);

  localparam int SLOT_W = CNT_W + 64;

  state_t             state_r, state_nxt;
  logic [31:0]        base_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               dirty_r, dirty_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [31:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [NODE_AW-1:0] nidx_r, nidx_nxt;
  logic [HASH_AW-1:0] pidx_r, pidx_nxt;
  logic [HASH_AW:0]   pn_r, pn_nxt;
  logic [HASH_AW-1:0] clr_r, clr_nxt;
  logic [31:0]        res_value_r, res_value_nxt;
  status_t            res_status_r, res_status_nxt;

  logic               out_valid_r;
  logic [31:0]        out_value_r;
  logic [1:0]         out_status_r;
  logic               out_dirty_r;
  logic [CNT_W-1:0]   out_nodes_r;

  logic               in_fire, out_load;
  fnv_req_t           fnv_req;
  fnv_rsp_t           fnv_rsp;

  logic               node_we;
  logic [NODE_AW-1:0] node_waddr;
  logic [63:0]        node_wdata, node_rdata;
  logic               slot_we;
  logic [HASH_AW-1:0] slot_waddr;
  logic [SLOT_W-1:0]  slot_wdata, slot_rdata;

  logic [31:0]        h_diff, t_diff;
  logic               h_ok, t_ok;
  logic [CNT_W-1:0]   slot_ref;
  logic               slot_hit, no_room;

  // memories
  hcps_ram #(.WIDTH(64), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(nidx_r), .rdata(node_rdata)
  );

  hcps_ram #(.WIDTH(SLOT_W), .DEPTH(HASH_DEPTH)) u_slot_ram (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(pidx_r), .rdata(slot_rdata)
  );

  hcps_fnv u_fnv (.clk, .rst_n, .req(fnv_req), .rsp(fnv_rsp));

  // handle checks against the node count
  assign h_diff = in_ch.handle - base_r;
  assign t_diff = in_ch.tail_value - base_r;
  assign h_ok = (in_ch.handle >= base_r) && (h_diff < 32'(cnt_r)) &&
                (in_ch.handle != base_r);
  assign t_ok = (in_ch.tail_value >= base_r) && (t_diff < 32'(cnt_r));

  // probe compare
  assign slot_ref = slot_rdata[SLOT_W-1 -: CNT_W];
  assign slot_hit = (slot_rdata[31:0] == head_r) && (slot_rdata[63:32] == tail_r);
  assign no_room  = ((32'(cnt_r) + 32'd1) > 32'(LOAD_LIMIT)) ||
                    (32'(cnt_r) >= 32'(NODE_DEPTH));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == HASH_AW'(HASH_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(in_ch.cmd))
            CMD_CONS: state_nxt = t_ok ? S_HASH : S_RESP;
            CMD_CAR, CMD_CDR: state_nxt = h_ok ? S_NRD : S_RESP;
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_HASH: if (fnv_rsp.done) state_nxt = S_PRD;
      S_PRD:  state_nxt = S_PCHK;
      S_PCHK: begin
        if (slot_ref == '0 || slot_hit || pn_r == (HASH_AW+1)'(HASH_DEPTH - 1)) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_NRD:  state_nxt = S_NSEL;
      S_NSEL: state_nxt = S_RESP;
      S_RESP: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_nxt        = cnt_r;
    dirty_nxt      = dirty_r;
    cmd_nxt        = cmd_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    nidx_nxt       = nidx_r;
    pidx_nxt       = pidx_r;
    pn_nxt         = pn_r;
    clr_nxt        = clr_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    fnv_req        = '0;
    node_we        = 1'b0;
    node_waddr     = cnt_r[NODE_AW-1:0];
    node_wdata     = {tail_r, head_r};
    slot_we        = 1'b0;
    slot_waddr     = pidx_r;
    slot_wdata     = {cnt_r, tail_r, head_r};
    case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        clr_nxt    = clr_r + HASH_AW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = cmd_t'(in_ch.cmd);
          head_nxt       = in_ch.head_value;
          tail_nxt       = in_ch.tail_value;
          nidx_nxt       = h_diff[NODE_AW-1:0];
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          case (cmd_t'(in_ch.cmd))
            CMD_CONS: begin
              if (t_ok) begin
                fnv_req.start = 1'b1;
                fnv_req.head  = in_ch.head_value;
                fnv_req.tail  = in_ch.tail_value;
              end else begin
                res_status_nxt = ST_REJECT;
              end
            end
            CMD_CLEAR: dirty_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      S_HASH: begin
        pidx_nxt = fnv_rsp.idx;
        pn_nxt   = '0;
      end
      S_PCHK: begin
        if (slot_ref == '0) begin
          if (no_room) begin
            res_status_nxt = ST_FULL;
          end else begin
            // allocate a new node
            node_we        = 1'b1;
            slot_we        = 1'b1;
            cnt_nxt        = cnt_r + CNT_W'(1);
            dirty_nxt      = 1'b1;
            res_value_nxt  = base_r + 32'(cnt_r);
            res_status_nxt = ST_NEW;
          end
        end else if (slot_hit) begin
          res_value_nxt  = base_r + 32'(slot_ref);
          res_status_nxt = ST_OK;
        end else if (pn_r == (HASH_AW+1)'(HASH_DEPTH - 1)) begin
          res_status_nxt = ST_FULL;
        end else begin
          pn_nxt   = pn_r + (HASH_AW+1)'(1);
          pidx_nxt = (pidx_r == HASH_AW'(HASH_DEPTH - 1)) ? '0 : pidx_r + HASH_AW'(1);
        end
      end
      S_NSEL: begin
        res_value_nxt = (cmd_r == CMD_CAR) ? node_rdata[31:0] : node_rdata[63:32];
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      base_r      <= BASE_RESET;
      cnt_r       <= CNT_W'(1);
      dirty_r     <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dirty_r <= dirty_nxt;
      clr_r   <= clr_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        base_r <= cfg_ch.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    cmd_r        <= cmd_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    nidx_r       <= nidx_nxt;
    pidx_r       <= pidx_nxt;
    pn_r         <= pn_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_dirty_r  <= dirty_r;
      out_nodes_r  <= cnt_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.dirty      = out_dirty_r;
  assign out_ch.nodes_used = out_nodes_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(1)) && (32'(cnt_r) <= 32'(NODE_DEPTH)))
    else $error("node count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("node count moved by more than one");
  a_new_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_NEW) |-> out_ch.dirty)
    else $error("new node reported with clean flag");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("item accepted during clearing pass");
  a_alloc_empty: assert property (@(posedge clk) disable iff (!rst_n)
    node_we |-> (slot_we && slot_ref == '0 && state_r == S_PCHK))
    else $error("node written outside an allocation");
`endif

endmodule

[bench/tb_pair_store_if.sv]
// Interface files for the pair store bench are taken from the RTL (hcps_if).
// This file holds the small helper package of bench-side types.
// Depends on hcps_pkg.
package tb_pair_store_pkg;
  import hcps_pkg::*;

  // One pending input item
  typedef struct packed {
    logic        is_cfg;
    logic [31:0] cfg_data;
    cmd_t        cmd;
    logic [31:0] head_value;
    logic [31:0] tail_value;
    logic [31:0] handle;
  } stim_item_t;

  // One expected result item
  typedef struct packed {
    logic [31:0] value;
    status_t     status;
    logic        dirty;
    logic [10:0] nodes_used;
  } result_item_t;
endpackage

[bench/tb_top.sv]
// Testbench for hash_consed_pair_store_core: directed and random commands,
// checked against an in-bench model of the interning table.
// Depends on hcps_pkg, hcps_if, tb_pair_store_pkg and the RTL.
module tb_top;
  import hcps_pkg::*;
  import tb_pair_store_pkg::*;

  logic clk;
  logic rst_n;

  hcps_in_if  in_ch();
  hcps_out_if out_ch();
  hcps_cfg_if cfg_ch();

  hash_consed_pair_store_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Model state
  logic [31:0] mdl_base;
  logic [31:0] mdl_node_head [NODE_DEPTH];
  logic [31:0] mdl_node_tail [NODE_DEPTH];
  logic [31:0] mdl_slot_head [HASH_DEPTH];
  logic [31:0] mdl_slot_tail [HASH_DEPTH];
  int unsigned mdl_slot_ref  [HASH_DEPTH];
  int unsigned mdl_count;
  logic        mdl_dirty;

  stim_item_t   pending_items[$];
  result_item_t expected_results[$];
  int           fail_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_cycles;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [31:0] w);
    for (int k = 0; k < 4; k++) begin
      h = h ^ {56'd0, w[8*k +: 8]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  function automatic logic is_list(logic [31:0] v);
    logic [31:0] off;
    off = v - mdl_base;
    return (v >= mdl_base) && (off < mdl_count);
  endfunction

  // Apply one command to the model and return its result
  function automatic result_item_t intern_step(stim_item_t it);
    result_item_t r;
    logic [63:0]  hv;
    int unsigned  idx;
    int unsigned  n;
    logic [31:0]  off;
    logic         found;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_CONS: begin
        if (!is_list(it.tail_value)) begin
          r.status = ST_REJECT;
        end else begin
          hv = fnv_mix(fnv_mix(FNV_OFFSET, it.head_value), it.tail_value);
          idx = hv[HASH_AW-1:0];
          found = 1'b0;
          for (n = 0; n < HASH_DEPTH; n++) begin
            if (mdl_slot_ref[idx] == 0) break;
            if (mdl_slot_head[idx] == it.head_value &&
                mdl_slot_tail[idx] == it.tail_value) begin
              found = 1'b1;
              break;
            end
            idx = (idx + 1) % HASH_DEPTH;
          end
          if (found) begin
            r.value = mdl_base + mdl_slot_ref[idx];
          end else if (n == HASH_DEPTH || mdl_count + 1 > LOAD_LIMIT ||
                       mdl_count >= NODE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            mdl_node_head[mdl_count] = it.head_value;
            mdl_node_tail[mdl_count] = it.tail_value;
            mdl_slot_head[idx] = it.head_value;
            mdl_slot_tail[idx] = it.tail_value;
            mdl_slot_ref[idx] = mdl_count;
            r.value = mdl_base + mdl_count;
            mdl_count++;
            mdl_dirty = 1'b1;
            r.status = ST_NEW;
          end
        end
      end
      CMD_CAR, CMD_CDR: begin
        off = it.handle - mdl_base;
        if (is_list(it.handle) && it.handle != mdl_base && off < NODE_DEPTH)
          r.value = (it.cmd == CMD_CDR) ? mdl_node_tail[off] : mdl_node_head[off];
      end
      default: mdl_dirty = 1'b0;
    endcase
    r.dirty = mdl_dirty;
    r.nodes_used = mdl_count[10:0];
    return r;
  endfunction

  // Driver: input and config channels share one ordered queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(intern_step(pending_items.pop_front()));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        mdl_base = pending_items[0].cfg_data;
        void'(pending_items.pop_front());
      end
      if ((in_ch.valid && !in_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
        // hold current item
      end else if (pending_items.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct &&
                   !(pending_items[0].is_cfg && expected_results.size() > 0)) begin
        in_ch.valid <= !pending_items[0].is_cfg;
        cfg_ch.valid <= pending_items[0].is_cfg;
        cfg_ch.data <= pending_items[0].cfg_data;
        in_ch.cmd <= pending_items[0].cmd;
        in_ch.head_value <= pending_items[0].head_value;
        in_ch.tail_value <= pending_items[0].tail_value;
        in_ch.handle <= pending_items[0].handle;
      end else begin
        in_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    result_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 out_ch.value, out_ch.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (want.value !== out_ch.value || want.status !== out_ch.status ||
            want.dirty !== out_ch.dirty || want.nodes_used !== out_ch.nodes_used) begin
          $display("%0t: mismatch expected v=%h s=%0d d=%0d n=%0d actual v=%h s=%0d d=%0d n=%0d",
                   $time, want.value, want.status, want.dirty, want.nodes_used,
                   out_ch.value, out_ch.status, out_ch.dirty, out_ch.nodes_used);
          fail_count++;
        end
      end
    end
  end

  function automatic stim_item_t mk(cmd_t c, logic [31:0] hd, logic [31:0] tl,
                                     logic [31:0] hn);
    stim_item_t it;
    it = '0;
    it.cmd = c;
    it.head_value = hd;
    it.tail_value = tl;
    it.handle = hn;
    return it;
  endfunction

  task automatic push_cfg(logic [31:0] b);
    stim_item_t it;
    it = '0;
    it.is_cfg = 1'b1;
    it.cfg_data = b;
    pending_items.push_back(it);
  endtask

  // Mostly valid-ish random commands around the current base
  task automatic push_random(int cnt, logic [31:0] b, int span);
    int sel;
    logic [31:0] hd;
    for (int i = 0; i < cnt; i++) begin
      sel = $urandom_range(99);
      hd = ($urandom_range(3) == 0) ? $urandom : $urandom_range(15);
      if (sel < 55)
        pending_items.push_back(mk(CMD_CONS, hd, b + $urandom_range(span), $urandom));
      else if (sel < 62)
        pending_items.push_back(mk(CMD_CONS, hd, $urandom, $urandom));
      else if (sel < 80)
        pending_items.push_back(mk(CMD_CAR, $urandom, $urandom, b + $urandom_range(span)));
      else if (sel < 94)
        pending_items.push_back(mk(CMD_CDR, $urandom, $urandom, b + $urandom_range(span)));
      else if (sel < 97)
        pending_items.push_back(mk(cmd_t'($urandom_range(1, 2)), 0, 0, $urandom));
      else
        pending_items.push_back(mk(CMD_CLEAR, $urandom, $urandom, $urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_results.size() > 0 ||
           in_ch.valid || cfg_ch.valid)
      @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.head_value = '0;
    in_ch.tail_value = '0;
    in_ch.handle = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    hold_cycles = 0;
    send_idle_pct = 9;
    recv_idle_pct = 49;
    mdl_base = BASE_RESET;
    mdl_count = 1;
    mdl_dirty = 1'b0;
    mdl_node_head[0] = '0;
    mdl_node_tail[0] = '0;
    for (int i = 0; i < HASH_DEPTH; i++) mdl_slot_ref[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset base, extremes, rejects, empty list reads
    pending_items.push_back(mk(CMD_CAR, 0, 0, BASE_RESET));
    pending_items.push_back(mk(CMD_CONS, 32'hFFFFFFFF, BASE_RESET, 0));
    pending_items.push_back(mk(CMD_CONS, 32'h0, BASE_RESET + 1, 0));
    pending_items.push_back(mk(CMD_CONS, 32'hFFFFFFFF, BASE_RESET, 0));
    pending_items.push_back(mk(CMD_CONS, 1, BASE_RESET + 9, 0));
    pending_items.push_back(mk(CMD_CONS, 1, BASE_RESET - 1, 0));
    pending_items.push_back(mk(CMD_CONS, 1, 32'hFFFFFFFF, 0));
    pending_items.push_back(mk(CMD_CAR, 0, 0, BASE_RESET + 1));
    pending_items.push_back(mk(CMD_CDR, 0, 0, BASE_RESET + 2));
    pending_items.push_back(mk(CMD_CDR, 0, 0, BASE_RESET));
    pending_items.push_back(mk(CMD_CAR, 0, 0, 32'hFFFFFFFF));
    pending_items.push_back(mk(CMD_CDR, 0, 0, 32'h0));
    pending_items.push_back(mk(CMD_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
    pending_items.push_back(mk(CMD_CONS, 32'h0, BASE_RESET, 0));
    pending_items.push_back(mk(CMD_CONS, 32'h0, BASE_RESET, 0));
    wait_drained();

    // Base at zero, then long receiver hold-off to back up the input
    push_cfg(32'h0);
    push_random(300, 32'h0, 40);
    wait_drained();
    push_cfg(32'hFFFFFC00);
    push_random(20, 32'hFFFFFC00, 40);
    hold_cycles = 600;
    push_random(300, 32'hFFFFFC00, 300);
    wait_drained();

    // Swap idling, fill toward the load limit with fresh pairs
    send_idle_pct = 49;
    recv_idle_pct = 9;
    push_cfg(32'h12345678);
    for (int i = 0; i < 450; i++)
      pending_items.push_back(mk(CMD_CONS, $urandom, 32'h12345678 + $urandom_range(700), 0));
    wait_drained();

    // No idling: table near/over full, reads of everything
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(350, 32'h12345678, 1100);
    push_cfg(BASE_RESET);
    push_random(30, BASE_RESET, 1100);
    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Timeout
  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[hash_consed_pair_store_core.f]
sv/hcps_pkg.sv
sv/hcps_if.sv
sv/hcps_ram.sv
sv/hcps_fnv.sv
sv/hash_consed_pair_store_core.sv
bench/tb_pair_store_if.sv
bench/tb_top.sv
